// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, off while in reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Next-cycle implication, off while in reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rvie_pkg.sv =====
// Shared types, constants and helpers for the RV64I integer execute block.
// No dependencies.
`default_nettype none

package rvie_pkg;

  localparam int XLEN          = 64;
  localparam int REG_IDX_W     = 5;
  localparam int IMM_W         = 21;
  localparam int CMD_W         = 6;
  localparam int REG_COUNT_DEF = 32;
  localparam logic [XLEN-1:0] PC_STEP = 64'd4;

  // Operation codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ADDI  = 6'd0,
    CMD_SLTI,
    CMD_SLTIU,
    CMD_ANDI,
    CMD_ORI,
    CMD_XORI,
    CMD_SLLI,
    CMD_SRLI,
    CMD_SRAI,
    CMD_LUI,
    CMD_AUIPC,
    CMD_ADD,
    CMD_SLT,
    CMD_SLTU,
    CMD_AND,
    CMD_OR,
    CMD_XOR,
    CMD_SLL,
    CMD_SRL,
    CMD_SUB,
    CMD_SRA,
    CMD_JAL,
    CMD_JALR,
    CMD_BEQ,
    CMD_BNE,
    CMD_BLT,
    CMD_BLTU,
    CMD_BGE,
    CMD_BGEU,
    CMD_ADDIW,
    CMD_SLLIW,
    CMD_SRLIW,
    CMD_SRAIW,
    CMD_ADDW,
    CMD_SUBW,
    CMD_SLLW,
    CMD_SRLW,
    CMD_SRAW
  } cmd_t;

  // Execute result handed from the ALU to the top level
  typedef struct packed {
    logic [XLEN-1:0] value;
    logic [XLEN-1:0] npc;
    logic            writes;
    logic            bad;
  } alu_res_t;

  // Sign-extend a 32-bit word to XLEN
  function automatic logic [XLEN-1:0] sext32(input logic [31:0] v);
    return {{(XLEN-32){v[31]}}, v};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rvie_in_if.sv =====
// Instruction channel: valid/ready handshake with the decoded instruction fields.
// Depends on nothing.
`default_nettype none

interface rvie_in_if;
  logic        valid;
  logic        ready;
  logic [5:0]  command;
  logic [4:0]  dest_reg;
  logic [4:0]  src_reg_a;
  logic [4:0]  src_reg_b;
  logic [20:0] raw_immediate;

  modport source (
    output valid, command, dest_reg, src_reg_a, src_reg_b, raw_immediate,
    input  ready
  );
  modport sink (
    input  valid, command, dest_reg, src_reg_a, src_reg_b, raw_immediate,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/rvie_out_if.sv =====
// Result channel: valid/ready handshake with register write and next PC.
// Depends on nothing.
`default_nettype none

interface rvie_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  write_index;
  logic [63:0] write_value;
  logic        write_done;
  logic [63:0] next_pc;
  logic        illegal;

  modport source (
    output valid, write_index, write_value, write_done, next_pc, illegal,
    input  ready
  );
  modport sink (
    input  valid, write_index, write_value, write_done, next_pc, illegal,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/rvie_ram.sv =====
// Generic RAM: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none

module rvie_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/rvie_alu.sv =====
// Combinational execute logic: ALU, W forms, jumps, branches and next PC.
// Depends on rvie_pkg.
`default_nettype none

module rvie_alu import rvie_pkg::*; (
  input  wire logic [CMD_W-1:0] cmd,
  input  wire logic [XLEN-1:0]  op_a,
  input  wire logic [XLEN-1:0]  op_b,
  input  wire logic [IMM_W-1:0] imm,
  input  wire logic [XLEN-1:0]  pc,
  output alu_res_t              res
);

  logic [XLEN-1:0] i12;
  logic [XLEN-1:0] b13;
  logic [XLEN-1:0] j21;
  logic [XLEN-1:0] up;
  logic [XLEN-1:0] pc4;
  logic [XLEN-1:0] a_imm;
  logic            taken;

  // Immediate forms
  assign i12   = {{(XLEN-12){imm[11]}}, imm[11:0]};
  assign b13   = {{(XLEN-13){imm[12]}}, imm[12:0]};
  assign j21   = {{(XLEN-21){imm[20]}}, imm};
  assign up    = {{(XLEN-32){imm[19]}}, imm[19:0], 12'b0};
  assign pc4   = pc + PC_STEP;
  assign a_imm = op_a + i12;

  always_comb begin
    res.value  = '0;
    res.npc    = pc4;
    res.writes = 1'b1;
    res.bad    = 1'b0;
    taken      = 1'b0;
    case (cmd_t'(cmd))
      CMD_ADDI:  res.value = a_imm;
      CMD_SLTI:  res.value = {63'b0, $signed(op_a) < $signed(i12)};
      CMD_SLTIU: res.value = {63'b0, op_a < i12};
      CMD_ANDI:  res.value = op_a & i12;
      CMD_ORI:   res.value = op_a | i12;
      CMD_XORI:  res.value = op_a ^ i12;
      CMD_SLLI:  res.value = op_a << imm[5:0];
      CMD_SRLI:  res.value = op_a >> imm[5:0];
      CMD_SRAI:  res.value = $signed(op_a) >>> imm[5:0];
      CMD_LUI:   res.value = up;
      CMD_AUIPC: res.value = pc + up;
      CMD_ADD:   res.value = op_a + op_b;
      CMD_SLT:   res.value = {63'b0, $signed(op_a) < $signed(op_b)};
      CMD_SLTU:  res.value = {63'b0, op_a < op_b};
      CMD_AND:   res.value = op_a & op_b;
      CMD_OR:    res.value = op_a | op_b;
      CMD_XOR:   res.value = op_a ^ op_b;
      CMD_SLL:   res.value = op_a << op_b[5:0];
      CMD_SRL:   res.value = op_a >> op_b[5:0];
      CMD_SUB:   res.value = op_a - op_b;
      CMD_SRA:   res.value = $signed(op_a) >>> op_b[5:0];
      CMD_JAL: begin
        res.value = pc4;
        res.npc   = pc + j21;
      end
      CMD_JALR: begin
        res.value = pc4;
        res.npc   = {a_imm[XLEN-1:1], 1'b0};
      end
      CMD_BEQ: begin
        res.writes = 1'b0;
        taken      = (op_a == op_b);
      end
      CMD_BNE: begin
        res.writes = 1'b0;
        taken      = (op_a != op_b);
      end
      CMD_BLT: begin
        res.writes = 1'b0;
        taken      = $signed(op_a) < $signed(op_b);
      end
      CMD_BLTU: begin
        res.writes = 1'b0;
        taken      = op_a < op_b;
      end
      CMD_BGE: begin
        res.writes = 1'b0;
        taken      = !($signed(op_a) < $signed(op_b));
      end
      CMD_BGEU: begin
        res.writes = 1'b0;
        taken      = !(op_a < op_b);
      end
      // 32-bit forms, sign-extended from bit 31
      CMD_ADDIW: res.value = sext32(a_imm[31:0]);
      CMD_SLLIW: res.value = sext32(op_a[31:0] << imm[4:0]);
      CMD_SRLIW: res.value = sext32(op_a[31:0] >> imm[4:0]);
      CMD_SRAIW: res.value = sext32($signed(op_a[31:0]) >>> imm[4:0]);
      CMD_ADDW:  res.value = sext32(op_a[31:0] + op_b[31:0]);
      CMD_SUBW:  res.value = sext32(op_a[31:0] - op_b[31:0]);
      CMD_SLLW:  res.value = sext32(op_a[31:0] << op_b[4:0]);
      CMD_SRLW:  res.value = sext32(op_a[31:0] >> op_b[4:0]);
      CMD_SRAW:  res.value = sext32($signed(op_a[31:0]) >>> op_b[4:0]);
      default: begin
        res.bad    = 1'b1;
        res.writes = 1'b0;
        res.npc    = pc;
      end
    endcase
    if (taken) begin
      res.npc = pc + b13;
    end
    if (!res.writes) begin
      res.value = '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rv64i_integer_execute.sv =====
// An input transfer goes to the execute register, then the result register drives out_ch.
// Throughput: one instruction per cycle unless out_ch stalls; register operands are read
// from the register-file RAM at the input transfer and bypassed from the execute stage.
// Reset (synchronous, active low) zeroes the PC and clears the per-register valid
// bits, so every register reads zero until written; no clearing pass is needed.
`default_nettype none

module rv64i_integer_execute import rvie_pkg::*; #(
  parameter int REG_COUNT = REG_COUNT_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rvie_in_if.sink     in_ch,
  rvie_out_if.source  out_ch
);

  `include "assert_macros.svh"

  localparam int AW = $clog2(REG_COUNT);
  localparam logic [REG_IDX_W:0] REG_LIM = (REG_IDX_W+1)'(REG_COUNT);

  // Handshake
  logic in_fire;
  logic in_ready;
  logic e_fire;

  // Execute stage registers
  logic                 e_valid_r;
  logic [CMD_W-1:0]     e_cmd_r;
  logic [REG_IDX_W-1:0] e_rd_r;
  logic [IMM_W-1:0]     e_imm_r;
  logic                 a_fwd_r, b_fwd_r;
  logic                 a_ok_r, b_ok_r;
  logic [XLEN-1:0]      fwd_val_r;

  // Architectural state
  logic [XLEN-1:0]      pc_r;
  logic [REG_COUNT-1:0] vld_r;

  // Result register
  logic                 out_valid_r;
  logic [REG_IDX_W-1:0] out_idx_r;
  logic [XLEN-1:0]      out_val_r;
  logic                 out_done_r;
  logic [XLEN-1:0]      out_npc_r;
  logic                 out_ill_r;

  logic [XLEN-1:0] ram_a, ram_b;
  logic [XLEN-1:0] op_a, op_b;
  logic            wr_en;
  logic            a_in_rng, b_in_rng;
  alu_res_t        alu;

  // Execute advances when the result register is free or draining
  assign e_fire   = e_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready = !e_valid_r || e_fire;
  assign in_fire  = in_ch.valid && in_ready;

  // Register write: x0 and indexes at or above REG_COUNT are dropped
  assign wr_en = e_fire && alu.writes && (e_rd_r != '0) && ({1'b0, e_rd_r} < REG_LIM);

  assign a_in_rng = {1'b0, in_ch.src_reg_a} < REG_LIM;
  assign b_in_rng = {1'b0, in_ch.src_reg_b} < REG_LIM;

  // Two copies of the register file, one per source operand
  rvie_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_a (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (e_rd_r[AW-1:0]),
    .wr_data (alu.value),
    .rd_en   (in_fire),
    .rd_addr (in_ch.src_reg_a[AW-1:0]),
    .rd_data (ram_a)
  );

  rvie_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_b (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (e_rd_r[AW-1:0]),
    .wr_data (alu.value),
    .rd_en   (in_fire),
    .rd_addr (in_ch.src_reg_b[AW-1:0]),
    .rd_data (ram_b)
  );

  // Operand select: bypass, stored value, or zero for unwritten registers
  assign op_a = a_fwd_r ? fwd_val_r : (a_ok_r ? ram_a : '0);
  assign op_b = b_fwd_r ? fwd_val_r : (b_ok_r ? ram_b : '0);

  rvie_alu u_alu (
    .cmd  (e_cmd_r),
    .op_a (op_a),
    .op_b (op_b),
    .imm  (e_imm_r),
    .pc   (pc_r),
    .res  (alu)
  );

  // Input transfer into the execute stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (in_fire) begin
      e_valid_r <= 1'b1;
    end else if (e_fire) begin
      e_valid_r <= 1'b0;
    end
    if (in_fire) begin
      e_cmd_r   <= in_ch.command;
      e_rd_r    <= in_ch.dest_reg;
      e_imm_r   <= in_ch.raw_immediate;
      a_ok_r    <= a_in_rng && vld_r[in_ch.src_reg_a[AW-1:0]];
      b_ok_r    <= b_in_rng && vld_r[in_ch.src_reg_b[AW-1:0]];
      a_fwd_r   <= wr_en && (e_rd_r == in_ch.src_reg_a);
      b_fwd_r   <= wr_en && (e_rd_r == in_ch.src_reg_b);
      fwd_val_r <= alu.value;
    end
  end

  // PC and register valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= '0;
      vld_r <= '0;
    end else begin
      if (e_fire && !alu.bad) begin
        pc_r <= alu.npc;
      end
      if (wr_en) begin
        vld_r[e_rd_r[AW-1:0]] <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (e_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (e_fire) begin
      out_idx_r  <= alu.writes ? e_rd_r : '0;
      out_val_r  <= alu.value;
      out_done_r <= alu.writes;
      out_npc_r  <= alu.npc;
      out_ill_r  <= alu.bad;
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.write_index = out_idx_r;
  assign out_ch.write_value = out_val_r;
  assign out_ch.write_done  = out_done_r;
  assign out_ch.next_pc     = out_npc_r;
  assign out_ch.illegal     = out_ill_r;

  // Checks
  `ASSERT_NEXT(a_in_to_exec, in_fire, e_valid_r, "accepted instruction missing in execute")
  `ASSERT_NEXT(a_exec_to_out, e_fire, out_valid_r, "executed instruction has no result")
  `ASSERT_NEXT(a_bad_keeps_pc, e_fire && alu.bad, $stable(pc_r), "illegal command moved PC")
  `ASSERT_CLK(a_x0_never_written, !vld_r[0], "x0 marked as written")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for rv64i_integer_execute: directed and random instruction streams.
// Depends on rvie_pkg, rvie_in_if, rvie_out_if and the rv64i_integer_execute RTL.
`timescale 1ns / 100ps

module testbench;
  import rvie_pkg::*;

  localparam int RANDOM_ITEMS  = 1260;
  localparam int TAIL_ITEMS    = 150;   // no idling once this few instructions remain
  localparam int IDLE_LIMIT    = 1000;  // cycles without any transfer before giving up
  localparam int FIRST_ILLEGAL = int'(CMD_SRAW) + 1;
  localparam int LAST_CODE     = 2 ** CMD_W - 1;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [REG_IDX_W-1:0] dest_reg;
    logic [REG_IDX_W-1:0] src_reg_a;
    logic [REG_IDX_W-1:0] src_reg_b;
    logic [IMM_W-1:0]     raw_immediate;
  } instr_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] write_index;
    logic [XLEN-1:0]      write_value;
    logic                 write_done;
    logic [XLEN-1:0]      next_pc;
    logic                 illegal;
  } writeback_t;

  logic clk;
  logic rst_n;

  rvie_in_if  in_ch ();
  rvie_out_if out_ch ();

  rv64i_integer_execute u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Architectural state mirrored by the predictor
  logic [XLEN-1:0] gpr [32];
  logic [XLEN-1:0] pc_model;

  instr_t     pending_instrs[$];
  writeback_t expected_writebacks[$];

  int mismatch_count = 0;
  int src_gap = 0;
  int sink_gap = 0;
  int src_idle_pct = 15;
  int sink_idle_pct = 15;
  int stall_cycles = 0;
  logic tail_phase;

  // Clock: 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Execute one instruction on the mirrored state and return its writeback
  function automatic writeback_t execute_model(instr_t ins);
    logic [XLEN-1:0] a, b, pc, i12, b13, j21, upper, res, npc;
    logic [31:0]     word;
    logic            writes, taken, bad, is_word;
    writeback_t      wb;
    a       = gpr[ins.src_reg_a];
    b       = gpr[ins.src_reg_b];
    pc      = pc_model;
    i12     = {{52{ins.raw_immediate[11]}}, ins.raw_immediate[11:0]};
    b13     = {{51{ins.raw_immediate[12]}}, ins.raw_immediate[12:0]};
    j21     = {{43{ins.raw_immediate[20]}}, ins.raw_immediate};
    upper   = {{32{ins.raw_immediate[19]}}, ins.raw_immediate[19:0], 12'h000};
    res     = '0;
    word    = '0;
    npc     = pc + PC_STEP;
    writes  = 1'b1;
    taken   = 1'b0;
    bad     = 1'b0;
    is_word = 1'b0;
    case (cmd_t'(ins.command))
      CMD_ADDI:  res = a + i12;
      CMD_SLTI:  res = {63'd0, $signed(a) < $signed(i12)};
      CMD_SLTIU: res = {63'd0, a < i12};
      CMD_ANDI:  res = a & i12;
      CMD_ORI:   res = a | i12;
      CMD_XORI:  res = a ^ i12;
      CMD_SLLI:  res = a << ins.raw_immediate[5:0];
      CMD_SRLI:  res = a >> ins.raw_immediate[5:0];
      CMD_SRAI:  res = $signed(a) >>> ins.raw_immediate[5:0];
      CMD_LUI:   res = upper;
      CMD_AUIPC: res = pc + upper;
      CMD_ADD:   res = a + b;
      CMD_SLT:   res = {63'd0, $signed(a) < $signed(b)};
      CMD_SLTU:  res = {63'd0, a < b};
      CMD_AND:   res = a & b;
      CMD_OR:    res = a | b;
      CMD_XOR:   res = a ^ b;
      CMD_SLL:   res = a << b[5:0];
      CMD_SRL:   res = a >> b[5:0];
      CMD_SUB:   res = a - b;
      CMD_SRA:   res = $signed(a) >>> b[5:0];
      CMD_JAL: begin
        res = pc + PC_STEP;
        npc = pc + j21;
      end
      CMD_JALR: begin
        res = pc + PC_STEP;
        npc = (a + i12) & ~64'd1;
      end
      CMD_BEQ: begin
        writes = 1'b0;
        taken  = (a == b);
      end
      CMD_BNE: begin
        writes = 1'b0;
        taken  = (a != b);
      end
      CMD_BLT: begin
        writes = 1'b0;
        taken  = $signed(a) < $signed(b);
      end
      CMD_BLTU: begin
        writes = 1'b0;
        taken  = a < b;
      end
      CMD_BGE: begin
        writes = 1'b0;
        taken  = !($signed(a) < $signed(b));
      end
      CMD_BGEU: begin
        writes = 1'b0;
        taken  = !(a < b);
      end
      // 32-bit forms: compute the low word, sign-extend below
      CMD_ADDIW: begin
        is_word = 1'b1;
        word    = a[31:0] + i12[31:0];
      end
      CMD_SLLIW: begin
        is_word = 1'b1;
        word    = a[31:0] << ins.raw_immediate[4:0];
      end
      CMD_SRLIW: begin
        is_word = 1'b1;
        word    = a[31:0] >> ins.raw_immediate[4:0];
      end
      CMD_SRAIW: begin
        is_word = 1'b1;
        word    = $signed(a[31:0]) >>> ins.raw_immediate[4:0];
      end
      CMD_ADDW: begin
        is_word = 1'b1;
        word    = a[31:0] + b[31:0];
      end
      CMD_SUBW: begin
        is_word = 1'b1;
        word    = a[31:0] - b[31:0];
      end
      CMD_SLLW: begin
        is_word = 1'b1;
        word    = a[31:0] << b[4:0];
      end
      CMD_SRLW: begin
        is_word = 1'b1;
        word    = a[31:0] >> b[4:0];
      end
      CMD_SRAW: begin
        is_word = 1'b1;
        word    = $signed(a[31:0]) >>> b[4:0];
      end
      default: begin
        bad    = 1'b1;
        writes = 1'b0;
        npc    = pc;
      end
    endcase

    if (is_word)
      res = {{32{word[31]}}, word};
    if (taken)
      npc = pc + b13;

    // x0 stays zero even though the write is reported
    if (writes && ins.dest_reg != '0)
      gpr[ins.dest_reg] = res;
    if (!writes)
      res = '0;
    if (!bad)
      pc_model = npc;

    wb.write_index = writes ? ins.dest_reg : '0;
    wb.write_value = res;
    wb.write_done  = writes;
    wb.next_pc     = npc;
    wb.illegal     = bad;
    return wb;
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 15;
      default: return 35;
    endcase
  endfunction

  // Bias toward a few low registers so results feed later instructions
  function automatic logic [REG_IDX_W-1:0] pick_reg();
    if ($urandom_range(0, 1) == 0)
      return REG_IDX_W'($urandom_range(0, 7));
    return REG_IDX_W'($urandom_range(0, 31));
  endfunction

  task automatic queue_instr(input logic [CMD_W-1:0] cmd, input int rd, input int rs1,
                             input int rs2, input int imm);
    instr_t ins;
    ins.command       = cmd;
    ins.dest_reg      = REG_IDX_W'(rd);
    ins.src_reg_a     = REG_IDX_W'(rs1);
    ins.src_reg_b     = REG_IDX_W'(rs2);
    ins.raw_immediate = IMM_W'(imm);
    pending_instrs.push_back(ins);
  endtask

  task automatic report_field(input string name, input logic [XLEN-1:0] want,
                              input logic [XLEN-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Instruction driver: predicts on every transfer, then offers the next item or idles
  always @(posedge clk) begin : instr_driver
    instr_t seen;
    instr_t nxt;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        seen.command       = in_ch.command;
        seen.dest_reg      = in_ch.dest_reg;
        seen.src_reg_a     = in_ch.src_reg_a;
        seen.src_reg_b     = in_ch.src_reg_b;
        seen.raw_immediate = in_ch.raw_immediate;
        expected_writebacks.push_back(execute_model(seen));
      end
      if ($urandom_range(0, 99) == 0)
        src_idle_pct = pick_idle_pct();
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_instrs.size() != 0 && !tail_phase &&
                     $urandom_range(0, 99) < src_idle_pct) begin
          src_gap = $urandom_range(0, 15);
          in_ch.valid <= 1'b0;
        end else if (pending_instrs.size() != 0) begin
          nxt = pending_instrs.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.command       <= nxt.command;
          in_ch.dest_reg      <= nxt.dest_reg;
          in_ch.src_reg_a     <= nxt.src_reg_a;
          in_ch.src_reg_b     <= nxt.src_reg_b;
          in_ch.raw_immediate <= nxt.raw_immediate;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      tail_phase <= (pending_instrs.size() < TAIL_ITEMS);
    end
  end

  // Writeback monitor: compares each transfer with the oldest prediction, stalls at random
  always @(posedge clk) begin : writeback_monitor
    writeback_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_writebacks.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result: expected none, actual next_pc %h",
                   $time, out_ch.next_pc);
        end else begin
          want = expected_writebacks.pop_front();
          report_field("write_index", XLEN'(want.write_index), XLEN'(out_ch.write_index));
          report_field("write_value", want.write_value, out_ch.write_value);
          report_field("write_done", XLEN'(want.write_done), XLEN'(out_ch.write_done));
          report_field("next_pc", want.next_pc, out_ch.next_pc);
          report_field("illegal", XLEN'(want.illegal), XLEN'(out_ch.illegal));
        end
      end
      if ($urandom_range(0, 99) == 0)
        sink_idle_pct = pick_idle_pct();
      if (sink_gap > 0) begin
        sink_gap--;
        out_ch.ready <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 99) < sink_idle_pct) begin
        sink_gap = $urandom_range(0, 15);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when neither channel has moved for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    instr_t ins;
    clk                 = 1'b0;
    rst_n               = 1'b0;
    tail_phase          = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.command       = '0;
    in_ch.dest_reg      = '0;
    in_ch.src_reg_a     = '0;
    in_ch.src_reg_b     = '0;
    in_ch.raw_immediate = '0;
    out_ch.ready        = 1'b0;
    for (int r = 0; r < 32; r++)
      gpr[r] = '0;
    pc_model = '0;

    // Directed: load corner operands, every operation once, then edge cases and illegal codes
    queue_instr(CMD_LUI, 1, 0, 0, 21'h080000);   // x1 = 0xffffffff80000000
    queue_instr(CMD_ADDI, 1, 1, 0, 21'h0007FF);  // low six bits all ones, bit 31 set
    queue_instr(CMD_ADDI, 2, 0, 0, 21'h000800);  // most negative 12-bit immediate
    queue_instr(CMD_LUI, 3, 0, 0, 21'h17FFFF);   // bit 20 ignored, x3 = 0x7ffff000
    queue_instr(CMD_ADDI, 0, 3, 0, 21'h000001);  // write to x0 is reported but dropped
    for (int c = int'(CMD_ADDI); c <= int'(CMD_SRAW); c++) begin
      case (c % 4)
        0: queue_instr(CMD_W'(c), 4 + c % 8, 1 + c % 3, 1 + (c + 1) % 3, 21'h1FFFFF);
        1: queue_instr(CMD_W'(c), 4 + c % 8, 1 + c % 3, 1 + (c + 1) % 3, 21'h100800);
        2: queue_instr(CMD_W'(c), 4 + c % 8, 1 + c % 3, 1 + (c + 1) % 3, 21'h0FF7FF);
        default: queue_instr(CMD_W'(c), 4 + c % 8, 1 + c % 3, 1 + (c + 1) % 3, 21'h000FFF);
      endcase
    end
    queue_instr(CMD_BEQ, 0, 1, 1, 21'h001000);   // taken, most negative branch offset
    queue_instr(CMD_JALR, 5, 1, 0, 21'h000000);  // odd target, bit 0 cleared
    queue_instr(CMD_ADD, 6, 6, 6, 0);            // same register as sources and destination
    queue_instr(CMD_W'(FIRST_ILLEGAL), 7, 1, 2, 21'h1FFFFF);
    queue_instr(CMD_W'(LAST_CODE), 8, 3, 1, 21'h000000);

    // Random: mostly legal instructions, a few unsupported codes
    repeat (RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0)
        ins.command = CMD_W'($urandom_range(FIRST_ILLEGAL, LAST_CODE));
      else
        ins.command = CMD_W'($urandom_range(int'(CMD_ADDI), int'(CMD_SRAW)));
      ins.dest_reg  = pick_reg();
      ins.src_reg_a = pick_reg();
      ins.src_reg_b = pick_reg();
      if ($urandom_range(0, 4) == 0)
        ins.src_reg_b = ins.src_reg_a;
      case ($urandom_range(0, 11))
        0:       ins.raw_immediate = 21'h000000;
        1:       ins.raw_immediate = 21'h0007FF;
        2:       ins.raw_immediate = 21'h000800;
        3:       ins.raw_immediate = 21'h000FFF;
        4:       ins.raw_immediate = 21'h001000;
        5:       ins.raw_immediate = 21'h0FFFFF;
        6:       ins.raw_immediate = 21'h100000;
        7:       ins.raw_immediate = 21'h1FFFFF;
        default: ins.raw_immediate = IMM_W'($urandom());
      endcase
      pending_instrs.push_back(ins);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: everything sent, every result back, then a few quiet cycles
    while (pending_instrs.size() != 0 || in_ch.valid || expected_writebacks.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rvie_pkg.sv
rtl/rvie_in_if.sv
rtl/rvie_out_if.sv
rtl/rvie_ram.sv
rtl/rvie_alu.sv
rtl/rv64i_integer_execute.sv
tb/testbench.sv
